### design/efre_pkg.sv
// ----------------------------------------------------------------------------
// efre_pkg
// Shared types, constants and tables of the frame rotation engine.
// ----------------------------------------------------------------------------
`default_nettype none
package efre_pkg;
    localparam int CORDIC_STEPS = 14;
    localparam int StepW = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [15:0] CLAMP_LO = 16'sd6362;
    localparam logic signed [15:0] CLAMP_HI = 16'sd6505;
    localparam logic signed [19:0] PI_Q16 = 20'sd205887;
    localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    localparam int NumLanes = 3;

    typedef struct packed {
        logic       req_type;
        logic [15:0] roll_angle;
        logic [15:0] pitch_angle;
        logic [15:0] yaw_angle;
        logic [15:0] attack_angle;
        logic [15:0] sideslip_angle;
        logic [3:0]  conversion;
        logic [31:0] vec_x;
        logic [31:0] vec_y;
        logic [31:0] vec_z;
    } t_req;

    typedef struct packed {
        logic [31:0] rot_x;
        logic [31:0] rot_y;
        logic [31:0] rot_z;
    } t_rsp;

    typedef logic signed [15:0] t_mat [9];

    function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
        logic signed [19:0] r;
        unique case (i)
            4'd0: r = 20'sd51472;  4'd1: r = 20'sd30386;
            4'd2: r = 20'sd16055;  4'd3: r = 20'sd8150;
            4'd4: r = 20'sd4091;   4'd5: r = 20'sd2047;
            4'd6: r = 20'sd1024;   4'd7: r = 20'sd512;
            4'd8: r = 20'sd256;    4'd9: r = 20'sd128;
            4'd10: r = 20'sd64;    4'd11: r = 20'sd32;
            4'd12: r = 20'sd16;    4'd13: r = 20'sd8;
            4'd14: r = 20'sd4;     default: r = 20'sd2;
        endcase
        return r;
    endfunction

    // stage code = matrix*2 + transpose
    function automatic logic [1:0] chain_len(input logic [3:0] c);
        logic [1:0] n;
        unique case (c)
            4'd7, 4'd8, 4'd11, 4'd12: n = 2'd2;
            4'd9, 4'd10:              n = 2'd3;
            4'd13, 4'd14, 4'd15:      n = 2'd0;
            default:                  n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] chain_stage(input logic [3:0] c, input logic [1:0] s);
        logic [11:0] t;
        unique case (c)
            4'd0: t = {4'd0, 4'd0, 4'd6};
            4'd1: t = {4'd0, 4'd0, 4'd7};
            4'd2: t = {4'd0, 4'd0, 4'd8};
            4'd3: t = {4'd0, 4'd0, 4'd0};
            4'd4: t = {4'd0, 4'd0, 4'd1};
            4'd5: t = {4'd0, 4'd0, 4'd2};
            4'd6: t = {4'd0, 4'd0, 4'd3};
            4'd7: t = {4'd0, 4'd6, 4'd1};
            4'd8: t = {4'd0, 4'd0, 4'd7};
            4'd9: t = {4'd2, 4'd0, 4'd7};
            4'd10: t = {4'd6, 4'd1, 4'd3};
            4'd11: t = {4'd0, 4'd2, 4'd0};
            4'd12: t = {4'd0, 4'd1, 4'd3};
            default: t = 12'd0;
        endcase
        unique case (s)
            2'd0: return t[3:0];
            2'd1: return t[7:4];
            default: return t[11:8];
        endcase
    endfunction
endpackage
`default_nettype wire

### design/efre_if.sv
// ----------------------------------------------------------------------------
// efre_req_if / efre_rsp_if
// Valid-ready channels carrying request and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface efre_req_if import efre_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface efre_rsp_if import efre_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/efre_cordic.sv
// ----------------------------------------------------------------------------
// efre_cordic
// Iterative sine/cosine unit, one rotation step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module efre_cordic import efre_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_angle,
    output logic                    o_done,
    output logic signed [15:0]      o_sin,
    output logic signed [15:0]      o_cos
);
    logic signed [33:0] r_x, r_y, n_x, n_y;
    logic signed [21:0] r_z, n_z;
    logic               r_flip;
    logic [StepW-1:0]   r_step;
    logic               r_busy, r_done;
    logic signed [21:0] z0, z1;
    logic signed [33:0] xs, ys;
    logic signed [17:0] xr, yr;
    logic signed [15:0] xo, yo;

    always_comb begin
        z0 = 22'(i_angle) <<< 4;
        if (z0 > 22'(PI_Q16)) z0 = z0 - 22'(TWO_PI_Q16);
        if (z0 < -22'(PI_Q16)) z0 = z0 + 22'(TWO_PI_Q16);
        z1 = z0;
        if (z0 > 22'(HALF_PI_Q16)) z1 = z0 - 22'(PI_Q16);
        else if (z0 < -22'(HALF_PI_Q16)) z1 = z0 + 22'(PI_Q16);
        xs = r_x >>> r_step;
        ys = r_y >>> r_step;
        if (r_z >= 0) begin
            n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - 22'(atan_q16(4'(r_step)));
        end else begin
            n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + 22'(atan_q16(4'(r_step)));
        end
        xr = 18'((r_x + 34'sd32768) >>> 16);
        yr = 18'((r_y + 34'sd32768) >>> 16);
        xo = (xr > 18'(ONE_Q14)) ? ONE_Q14 : (xr < -18'(ONE_Q14)) ? -ONE_Q14 : 16'(xr);
        yo = (yr > 18'(ONE_Q14)) ? ONE_Q14 : (yr < -18'(ONE_Q14)) ? -ONE_Q14 : 16'(yr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == StepW'(CORDIC_STEPS));
            if (i_start) begin
                r_busy <= 1'b1;
                r_x <= 34'(GAIN_Q30);
                r_y <= '0;
                r_z <= (z0 > 22'(HALF_PI_Q16) || z0 < -22'(HALF_PI_Q16)) ? z1 : z0;
                r_flip <= (z0 > 22'(HALF_PI_Q16) || z0 < -22'(HALF_PI_Q16));
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == StepW'(CORDIC_STEPS)) begin
                    r_busy <= 1'b0;
                    o_cos <= r_flip ? -xo : xo;
                    o_sin <= r_flip ? -yo : yo;
                end else begin
                    r_x <= n_x; r_y <= n_y; r_z <= n_z;
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
endmodule
`default_nettype wire

### design/efre_lane.sv
// ----------------------------------------------------------------------------
// efre_lane
// One dot-product lane: three products, exact sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module efre_lane import efre_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic               i_wide,
    input  wire logic signed [15:0] i_a0,
    input  wire logic signed [15:0] i_a1,
    input  wire logic signed [15:0] i_a2,
    input  wire logic signed [31:0] i_b0,
    input  wire logic signed [31:0] i_b1,
    input  wire logic signed [31:0] i_b2,
    output logic signed [31:0]      o_res
);
    logic signed [47:0] r_p0, r_p1, r_p2;
    logic signed [49:0] sum;
    logic signed [35:0] rnd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_a0 * i_b0;
            r_p1 <= i_a1 * i_b1;
            r_p2 <= i_a2 * i_b2;
        end
    end

    always_comb begin
        sum = 50'(r_p0) + 50'(r_p1) + 50'(r_p2) + 50'sd8192;
        rnd = 36'(sum >>> 14);
        if (i_wide) begin
            if ((sum >>> 14) > 50'sd2147483647) o_res = 32'sh7fffffff;
            else if ((sum >>> 14) < -50'sd2147483648) o_res = 32'sh80000000;
            else o_res = 32'(rnd);
        end else begin
            if (rnd > 36'sd32767) o_res = 32'sd32767;
            else if (rnd < -36'sd32768) o_res = -32'sd32768;
            else o_res = 32'(rnd);
        end
    end
endmodule
`default_nettype wire

### design/euler_frame_rotation_engine.sv
// ----------------------------------------------------------------------------
// euler_frame_rotation_engine
// Euler angle matrices and frame conversion of Q16.16 vectors.
//
//  channel  dir  payload
//  i_req    in   req_type, five angles, conversion, vec_x/y/z
//  o_rsp    out  rot_x, rot_y, rot_z (rotate items only)
//
// update: five cordic passes, then 27 product steps. rotate: up to three
// stages on three shared dot-product lanes.
// one item at a time; result held in an output register until taken.
// reset clears the matrix store and the control state.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_frame_rotation_engine import efre_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    efre_req_if.sink   i_req,
    efre_rsp_if.source o_rsp
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_CORD = 6'b000010, S_MUL = 6'b000100,
        S_ROT = 6'b001000, S_OUT = 6'b010000, S_WAIT = 6'b100000
    } t_state;

    t_state r_state;
    t_req   r_req;
    t_mat   r_myaw, r_mpit, r_mrol, r_mvb, r_mwb;
    t_mat   msel;
    logic signed [15:0] r_sc [10];
    logic [2:0] r_ang;
    logic [4:0] r_mi;
    logic [1:0] r_stg;
    logic       r_ph;
    logic signed [31:0] r_v [3];
    logic signed [15:0] r_t [9];
    logic cstart, cdone;
    logic signed [15:0] csin, ccos, cang;
    logic signed [15:0] mag;
    logic signed [15:0] a [3][3];
    logic signed [31:0] b [3];
    logic signed [31:0] lres [3];
    logic [3:0] code;
    logic [2:0] mm;
    logic signed [15:0] pit [9], yaw [9], rol [9], bst [9], swt [9];
    logic [1:0] rr, cc;
    logic [2:0] prod;
    logic [3:0] pos;

    always_comb begin
        unique case (r_ang)
            3'd0: cang = r_req.roll_angle;
            3'd1: cang = r_req.pitch_angle;
            3'd2: cang = r_req.yaw_angle;
            3'd3: cang = r_req.attack_angle;
            default: cang = r_req.sideslip_angle;
        endcase
        mag = cang[15] ? -cang : cang;
        if (r_ang < 3'd2 && mag > CLAMP_LO && mag < CLAMP_HI)
            cang = cang[15] ? -CLAMP_LO : CLAMP_LO;
    end

    assign cstart = (r_state == S_CORD) && !r_ph;

    efre_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cstart), .i_angle(cang),
        .o_done(cdone), .o_sin(csin), .o_cos(ccos)
    );

    // sc: sp cp st ct sy cy sa ca sb cb
    always_comb begin
        yaw = '{r_sc[5], r_sc[4], 16'sd0, -r_sc[4], r_sc[5], 16'sd0, 16'sd0, 16'sd0, ONE_Q14};
        pit = '{r_sc[3], 16'sd0, -r_sc[2], 16'sd0, ONE_Q14, 16'sd0, r_sc[2], 16'sd0, r_sc[3]};
        rol = '{ONE_Q14, 16'sd0, 16'sd0, 16'sd0, r_sc[1], r_sc[0], 16'sd0, -r_sc[0], r_sc[1]};
        bst = '{r_sc[7], 16'sd0, -r_sc[6], 16'sd0, ONE_Q14, 16'sd0, r_sc[6], 16'sd0, r_sc[7]};
        swt = '{r_sc[9], -r_sc[8], 16'sd0, r_sc[8], r_sc[9], 16'sd0, 16'sd0, 16'sd0, ONE_Q14};
        // r_mi: product (0 tmp,1 vb,2 wb) *9 + row*3 + col ; lanes over k
        prod = (r_mi < 5'd9) ? 3'd0 : (r_mi < 5'd18) ? 3'd1 : 3'd2;
        pos = 4'(r_mi - 5'(prod) * 5'd9);
        unique case (pos)
            4'd0: begin rr = 2'd0; cc = 2'd0; end
            4'd1: begin rr = 2'd0; cc = 2'd1; end
            4'd2: begin rr = 2'd0; cc = 2'd2; end
            4'd3: begin rr = 2'd1; cc = 2'd0; end
            4'd4: begin rr = 2'd1; cc = 2'd1; end
            4'd5: begin rr = 2'd1; cc = 2'd2; end
            4'd6: begin rr = 2'd2; cc = 2'd0; end
            4'd7: begin rr = 2'd2; cc = 2'd1; end
            default: begin rr = 2'd2; cc = 2'd2; end
        endcase
        code = chain_stage(r_req.conversion, r_stg);
        mm = (code[3:1] > 3'd4) ? code[3:1] - 3'd5 : code[3:1];
        unique case (mm)
            3'd0: msel = r_myaw;
            3'd1: msel = r_mpit;
            3'd2: msel = r_mrol;
            3'd3: msel = r_mvb;
            default: msel = r_mwb;
        endcase
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                a[r][k] = code[0] ? msel[k * 3 + r] : msel[r * 3 + k];
            end
            b[r] = r_v[r];
        end
        if (r_state == S_MUL) begin
            for (int k = 0; k < 3; k++) begin
                unique case (prod)
                    3'd0: begin
                        a[k][0] = pit[int'(rr) * 3 + k];
                        b[k] = 32'(yaw[k * 3 + int'(cc)]);
                    end
                    3'd1: begin
                        a[k][0] = rol[int'(rr) * 3 + k];
                        b[k] = 32'(r_t[k * 3 + int'(cc)]);
                    end
                    default: begin
                        a[k][0] = bst[int'(rr) * 3 + k];
                        b[k] = 32'(swt[k * 3 + int'(cc)]);
                    end
                endcase
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NumLanes; g++) begin : g_lane
            logic signed [15:0] la0, la1, la2;
            logic signed [31:0] lb0, lb1, lb2;
            always_comb begin
                if (r_state == S_MUL) begin
                    la0 = a[0][0]; la1 = a[1][0]; la2 = a[2][0];
                    lb0 = b[0]; lb1 = b[1]; lb2 = b[2];
                end else begin
                    la0 = a[g][0]; la1 = a[g][1]; la2 = a[g][2];
                    lb0 = b[0]; lb1 = b[1]; lb2 = b[2];
                end
            end
            efre_lane u_lane (
                .i_clk(i_clk), .i_en(!r_ph), .i_wide(r_state == S_ROT),
                .i_a0(la0), .i_a1(la1), .i_a2(la2),
                .i_b0(lb0), .i_b1(lb1), .i_b2(lb2), .o_res(lres[g])
            );
        end
    endgenerate

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data.rot_x = r_v[0];
    assign o_rsp.data.rot_y = r_v[1];
    assign o_rsp.data.rot_z = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_myaw[k] <= '0;
                r_mpit[k] <= '0;
                r_mrol[k] <= '0;
                r_mvb[k] <= '0;
                r_mwb[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_v[0] <= i_req.data.vec_x;
                        r_v[1] <= i_req.data.vec_y;
                        r_v[2] <= i_req.data.vec_z;
                        r_ang <= '0;
                        r_mi <= '0;
                        r_stg <= '0;
                        r_ph <= 1'b0;
                        if (!i_req.data.req_type) r_state <= S_CORD;
                        else if (chain_len(i_req.data.conversion) == 2'd0) r_state <= S_OUT;
                        else r_state <= S_ROT;
                    end
                end
                S_CORD: begin
                    if (cdone) begin
                        r_sc[int'(r_ang) * 2] <= csin;
                        r_sc[int'(r_ang) * 2 + 1] <= ccos;
                        r_ph <= 1'b0;
                        if (r_ang == 3'd4) r_state <= S_MUL;
                        r_ang <= r_ang + 1'b1;
                    end else begin
                        r_ph <= 1'b1;
                    end
                end
                S_MUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        unique case (prod)
                            3'd0: r_t[int'(rr) * 3 + int'(cc)] <= 16'(lres[0]);
                            3'd1: r_mvb[int'(rr) * 3 + int'(cc)] <= 16'(lres[0]);
                            default: r_mwb[int'(rr) * 3 + int'(cc)] <= 16'(lres[0]);
                        endcase
                        if (r_mi == 5'd26) begin
                            r_myaw <= yaw;
                            r_mpit <= pit;
                            r_mrol <= rol;
                            r_state <= S_WAIT;
                        end
                        r_mi <= r_mi + 1'b1;
                    end
                end
                S_ROT: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        for (int k = 0; k < 3; k++) r_v[k] <= lres[k];
                        if (r_stg + 1'b1 == chain_len(r_req.conversion)) r_state <= S_OUT;
                        r_stg <= r_stg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) r_state <= S_IDLE;
                end
                S_WAIT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/efre_checker.sv
// ----------------------------------------------------------------------------
// efre_checker
// Port-level checks of the frame rotation engine.
// ----------------------------------------------------------------------------
`default_nettype none
module efre_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire logic [31:0] i_rot_x
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rot_x))
        else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready) else $error("ready after accept");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_ready |=> !i_rsp_valid) else $error("result repeated");
endmodule

bind euler_frame_rotation_engine efre_checker u_efre_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready),
    .i_rot_x(o_rsp.data.rot_x)
);
`default_nettype wire
